// ===== rtl/core/mmn_pkg.sv =====
package mmn_pkg;

  // Output level width and the top display level
  localparam int unsigned LEVEL_BITS = 8;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'd255;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN = 8'd0;

  // Request codes carried on in_req_type
  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  // Status of one pass through the shared subtractor
  typedef struct packed {
    logic borrow;  // a < b
    logic zero;    // a == b
  } sub_flags_t;

endpackage

// ===== rtl/core/mmn_sub.sv =====
module mmn_sub
  import mmn_pkg::*;
#(
  parameter int unsigned WIDTH = 40
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output sub_flags_t       flags
);

  logic [WIDTH:0] full;

  // Unsigned subtract; the extra top bit is the borrow
  assign full         = {1'b0, a} - {1'b0, b};
  assign diff         = full[WIDTH-1:0];
  assign flags.borrow = full[WIDTH];
  assign flags.zero   = (full == '0);

endmodule

// ===== rtl/core/minmax_normalize_to_byte.sv =====
// Min-max contrast stretch of raw samples to 8-bit display levels.
// Input: in_req_type, in_sample, in_first, taken on a rising edge with
// start high and busy low. A measure item (in_req_type 0) widens the
// running bounds; with in_first set it restarts them from the sample.
// A convert item (in_req_type 1) returns one result on out_level and
// out_flat, marked by a one-cycle out_valid strobe; the receiver takes
// it in that cycle and cannot stall it.
// The sequence of states is set by the single shared subtractor that does
// every compare, the 255x scaling and the restoring divide:
//   measure with in_first: busy stays low, no compare states
//   measure without in_first: busy for a low compare, then a high compare
//   convert: the range check ends a flat range, the offset check a sample
//   at or under the low bound, the top check one at or over the high bound;
//   else range, offset, top check, scale, 8 divide steps.
// busy drops in the strobe cycle, so a new item may transfer then.
// cfg_we/cfg_wdata write byte_mode (bounds fixed at 0 and 255 for
// converts). Reset clears byte_mode and both bounds to zero.
module minmax_normalize_to_byte
  import mmn_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic signed [31:0]    in_sample,
  input  logic                  in_first,
  output logic                  out_valid,
  output logic [LEVEL_BITS-1:0] out_level,
  output logic                  out_flat
);

  localparam int unsigned W  = SAMPLE_BITS;
  localparam int unsigned SW = SAMPLE_BITS + LEVEL_BITS;
  localparam int unsigned STEP_BITS = $clog2(LEVEL_BITS);
  localparam logic [W-1:0] SIGN_MASK = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] BYTE_LO   = SIGN_MASK;
  localparam logic [W-1:0] BYTE_HI   = W'(255) ^ SIGN_MASK;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAS_LO,
    ST_MEAS_HI,
    ST_RANGE,
    ST_NUM,
    ST_TOP,
    ST_SCALE,
    ST_DIV
  } state_t;

  state_t                state_r;
  logic                  byte_mode_r;
  logic [W-1:0]          low_ord_r;
  logic [W-1:0]          high_ord_r;
  logic [W-1:0]          os_r;
  logic [W-1:0]          cmp_lo_r;
  logic [W-1:0]          cmp_hi_r;
  logic [W-1:0]          num_r;
  logic [SW-1:0]         rem_r;
  logic [SW-1:0]         dshift_r;
  logic [LEVEL_BITS-1:0] q_r;
  logic [STEP_BITS-1:0]  step_r;
  logic                  out_valid_r;
  logic [LEVEL_BITS-1:0] out_level_r;
  logic                  out_flat_r;

  logic [63:0]   sample_ext;
  logic [W-1:0]  sample_ord;
  logic          take;
  logic [SW-1:0] sub_a;
  logic [SW-1:0] sub_b;
  logic [SW-1:0] sub_diff;
  sub_flags_t    sub_flags;

  // Sign-extend, keep SAMPLE_BITS, flip the sign bit so unsigned order works
  assign sample_ext = {{32{in_sample[31]}}, in_sample};
  assign sample_ord = sample_ext[W-1:0] ^ SIGN_MASK;
  assign take       = start && !busy;

  // Route operands into the shared subtractor
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_r)
      ST_MEAS_LO: begin
        sub_a = {{LEVEL_BITS{1'b0}}, os_r};
        sub_b = {{LEVEL_BITS{1'b0}}, low_ord_r};
      end
      ST_MEAS_HI: begin
        sub_a = {{LEVEL_BITS{1'b0}}, high_ord_r};
        sub_b = {{LEVEL_BITS{1'b0}}, os_r};
      end
      ST_RANGE: begin
        sub_a = {{LEVEL_BITS{1'b0}}, cmp_hi_r};
        sub_b = {{LEVEL_BITS{1'b0}}, cmp_lo_r};
      end
      ST_NUM: begin
        sub_a = {{LEVEL_BITS{1'b0}}, os_r};
        sub_b = {{LEVEL_BITS{1'b0}}, cmp_lo_r};
      end
      ST_TOP: begin
        sub_a = {{LEVEL_BITS{1'b0}}, os_r};
        sub_b = {{LEVEL_BITS{1'b0}}, cmp_hi_r};
      end
      ST_SCALE: begin
        sub_a = {num_r, {LEVEL_BITS{1'b0}}};
        sub_b = {{LEVEL_BITS{1'b0}}, num_r};
      end
      ST_DIV: begin
        sub_a = rem_r;
        sub_b = dshift_r;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  mmn_sub #(
    .WIDTH (SW)
  ) u_sub (
    .a     (sub_a),
    .b     (sub_b),
    .diff  (sub_diff),
    .flags (sub_flags)
  );

  // Sequencer, bounds and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      byte_mode_r <= 1'b0;
      low_ord_r   <= SIGN_MASK;
      high_ord_r  <= SIGN_MASK;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        byte_mode_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            os_r <= sample_ord;
            if (in_req_type == REQ_CONVERT) begin
              cmp_lo_r <= byte_mode_r ? BYTE_LO : low_ord_r;
              cmp_hi_r <= byte_mode_r ? BYTE_HI : high_ord_r;
              state_r  <= ST_RANGE;
            end else if (in_first) begin
              low_ord_r  <= sample_ord;
              high_ord_r <= sample_ord;
            end else begin
              state_r <= ST_MEAS_LO;
            end
          end
        end
        ST_MEAS_LO: begin
          // Sample below the running minimum
          if (sub_flags.borrow) begin
            low_ord_r <= os_r;
          end
          state_r <= ST_MEAS_HI;
        end
        ST_MEAS_HI: begin
          // Running maximum below the sample
          if (sub_flags.borrow) begin
            high_ord_r <= os_r;
          end
          state_r <= ST_IDLE;
        end
        ST_RANGE: begin
          // Flat range ends the item at once
          dshift_r <= {1'b0, sub_diff[W-1:0], {(LEVEL_BITS-1){1'b0}}};
          if (sub_flags.zero) begin
            out_valid_r <= 1'b1;
            out_level_r <= LEVEL_MIN;
            out_flat_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            state_r <= ST_NUM;
          end
        end
        ST_NUM: begin
          // Sample at or under the low bound clamps to zero
          num_r <= sub_diff[W-1:0];
          if (sub_flags.borrow || sub_flags.zero) begin
            out_valid_r <= 1'b1;
            out_level_r <= LEVEL_MIN;
            out_flat_r  <= 1'b0;
            state_r     <= ST_IDLE;
          end else begin
            state_r <= ST_TOP;
          end
        end
        ST_TOP: begin
          // Sample at or over the high bound clamps to full scale
          if (!sub_flags.borrow) begin
            out_valid_r <= 1'b1;
            out_level_r <= LEVEL_MAX;
            out_flat_r  <= 1'b0;
            state_r     <= ST_IDLE;
          end else begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          // 255 * num as (num << 8) - num
          rem_r   <= sub_diff;
          q_r     <= '0;
          step_r  <= STEP_BITS'(LEVEL_BITS - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          // One restoring divide step per cycle, quotient MSB first
          if (!sub_flags.borrow) begin
            rem_r <= sub_diff;
          end
          q_r      <= {q_r[LEVEL_BITS-2:0], !sub_flags.borrow};
          dshift_r <= dshift_r >> 1;
          step_r   <= step_r - 1'b1;
          if (step_r == '0) begin
            out_valid_r <= 1'b1;
            out_level_r <= {q_r[LEVEL_BITS-2:0], !sub_flags.borrow};
            out_flat_r  <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_flat  = out_flat_r;

  // A result strobe only appears once the sequencer is back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  // A flat range always reports level zero
  a_flat_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flat) |-> (out_level == LEVEL_MIN))
    else $error("flat result with nonzero level");

  // A convert transfer always starts the sequencer
  a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_req_type == REQ_CONVERT) |=> busy)
    else $error("convert transfer did not start sequencer");

  // Each strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Tracked bounds never cross
  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    !(high_ord_r < low_ord_r))
    else $error("high bound below low bound");

endmodule

// ===== tb/minmax_normalize_to_byte_tb.sv =====
module minmax_normalize_to_byte_tb
  import mmn_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_RANGE = 1'b0;  // converts use the tracked bounds
  localparam logic MODE_BYTE  = 1'b1;  // converts use fixed bounds 0 and 255
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_ITEMS = 235;
  localparam int DRAIN_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic               req;
    logic signed [31:0] sample;
    logic               first;
    logic               hold;  // wait for every pending result before presenting
  } sample_item_t;

  typedef struct {
    logic [LEVEL_BITS-1:0] level;
    logic                  flat;
  } level_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = REQ_MEASURE;
  logic signed [31:0] in_sample = '0;
  logic in_first = 1'b0;
  logic out_valid;
  logic [LEVEL_BITS-1:0] out_level;
  logic out_flat;

  sample_item_t sample_q[$];
  level_res_t level_q[$];
  int idle_pct = 0;
  int fail_count = 0;

  // Shadow of the block's register and running bounds
  logic mode_shadow = MODE_RANGE;
  logic signed [31:0] trk_lo = '0;
  logic signed [31:0] trk_hi = '0;

  minmax_normalize_to_byte dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_sample(in_sample),
    .in_first(in_first),
    .out_valid(out_valid),
    .out_level(out_level),
    .out_flat(out_flat)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Level for one converted sample against the current bounds
  function automatic level_res_t stretch_level(input logic signed [31:0] x);
    level_res_t res;
    longint lo, hi, num, den;
    lo = mode_shadow ? 64'sd0 : longint'(trk_lo);
    hi = mode_shadow ? 64'sd255 : longint'(trk_hi);
    res.flat = 1'b0;
    if (hi == lo) begin
      res.flat = 1'b1;
      res.level = LEVEL_MIN;
    end else if (longint'(x) <= lo) begin
      res.level = LEVEL_MIN;
    end else if (longint'(x) >= hi) begin
      res.level = LEVEL_MAX;
    end else begin
      num = longint'(x) - lo;
      den = hi - lo;
      res.level = LEVEL_BITS'((num * 255) / den);
    end
    return res;
  endfunction

  // Driver: present the head of the pending queue, hold it until transfer
  always @(posedge clk) begin
    logic sent;
    logic go;
    sent = start && !busy;
    go = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (sent) void'(sample_q.pop_front());
      if (!start || sent) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          go = !sample_q[0].hold || (!start && !busy && level_q.size() == 0);
        end
        if (go) begin
          start <= 1'b1;
          in_req_type <= sample_q[0].req;
          in_sample <= sample_q[0].sample;
          in_first <= sample_q[0].first;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results, track config writes and predict each transfer
  always @(posedge clk) begin
    level_res_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (level_q.size() == 0) begin
          $error("out_valid with no result pending: level %0d flat %0b", out_level, out_flat);
          fail_count++;
        end else begin
          want = level_q.pop_front();
          if (out_level !== want.level) begin
            $error("out_level mismatch: expected %0d, got %0d", want.level, out_level);
            fail_count++;
          end
          if (out_flat !== want.flat) begin
            $error("out_flat mismatch: expected %0b, got %0b", want.flat, out_flat);
            fail_count++;
          end
        end
      end
      if (cfg_we) mode_shadow = cfg_wdata;
      if (start && !busy) begin
        if (in_req_type == REQ_MEASURE) begin
          if (in_first) begin
            trk_lo = in_sample;
            trk_hi = in_sample;
          end else begin
            if (in_sample < trk_lo) trk_lo = in_sample;
            if (in_sample > trk_hi) trk_hi = in_sample;
          end
        end else begin
          level_q.push_back(stretch_level(in_sample));
        end
      end
    end
  end

  task automatic add_item(input logic req, input logic signed [31:0] s, input logic first,
                          input logic hold = 1'b0);
    sample_item_t it;
    it.req = req;
    it.sample = s;
    it.first = first;
    it.hold = hold;
    sample_q.push_back(it);
  endtask

  // Wait until the block and both queues are quiet, then let it settle
  task automatic wait_idle();
    int n;
    n = 0;
    @(negedge clk);
    while ((sample_q.size() != 0 || start || busy || level_q.size() != 0) &&
           n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (n >= DRAIN_LIMIT) begin
      $error("block did not go idle: %0d items and %0d results pending",
             sample_q.size(), level_q.size());
      fail_count++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_byte_mode(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random frame: mostly measure pass then convert pass, some noise
  task automatic queue_frame(inout int budget);
    logic signed [31:0] seen[8];
    logic signed [31:0] base;
    int kind, shift, n_meas, n_conv, n;
    kind = $urandom_range(9);
    shift = $urandom_range(31);
    base = $urandom;
    if (kind == 0) begin
      // noise: any mix of fields
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        add_item(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
      end
      budget -= n;
    end else begin
      n_meas = $urandom_range(1, 8);
      n_conv = $urandom_range(1, 8);
      for (int i = 0; i < n_meas; i++) begin
        seen[i] = base + ($urandom >> shift);
        // broken frames skip the first flag
        if (kind != 1) add_item(REQ_MEASURE, seen[i], i == 0, i == 0 && $urandom_range(24) == 0);
        else add_item(REQ_MEASURE, seen[i], 1'b0);
      end
      for (int i = 0; i < n_conv; i++) begin
        case ($urandom_range(3))
          0: add_item(REQ_CONVERT, seen[$urandom_range(n_meas - 1)], 1'($urandom_range(1)));
          1: add_item(REQ_CONVERT, $urandom, 1'($urandom_range(1)));
          default: add_item(REQ_CONVERT, base + ($urandom >> shift), 1'($urandom_range(1)));
        endcase
      end
      budget -= n_meas + n_conv;
    end
  endtask

  initial begin
    int budget;
    int idle_tab[PHASE_COUNT];
    logic mode_tab[PHASE_COUNT];
    idle_tab = '{0, 81, 0, 34, 81, 0};
    mode_tab = '{MODE_RANGE, MODE_BYTE, MODE_RANGE, MODE_RANGE, MODE_BYTE, MODE_RANGE};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_byte_mode(MODE_RANGE);

    // Directed: bounds from reset, widening, extremes, flat frames
    add_item(REQ_CONVERT, 32'sd5, 1'b0);
    add_item(REQ_MEASURE, 32'sd100, 1'b0);
    add_item(REQ_MEASURE, -32'sd50, 1'b0);
    add_item(REQ_CONVERT, 32'sd25, 1'b0);
    add_item(REQ_CONVERT, -32'sd50, 1'b0);
    add_item(REQ_CONVERT, -32'sd60, 1'b0);
    add_item(REQ_CONVERT, 32'sd100, 1'b0);
    add_item(REQ_CONVERT, 32'sh7fffffff, 1'b0);
    add_item(REQ_MEASURE, 32'sh80000000, 1'b1);
    add_item(REQ_MEASURE, 32'sh7fffffff, 1'b0);
    add_item(REQ_CONVERT, 32'sd0, 1'b0);
    add_item(REQ_CONVERT, 32'sh80000000, 1'b0);
    add_item(REQ_CONVERT, 32'sh7ffffffe, 1'b0);
    add_item(REQ_CONVERT, -32'sd1, 1'b1);
    add_item(REQ_CONVERT, 32'sd1, 1'b0);
    add_item(REQ_MEASURE, 32'sd7, 1'b1);
    add_item(REQ_CONVERT, 32'sd7, 1'b1, 1'b1);
    add_item(REQ_MEASURE, 32'sd7, 1'b1);
    add_item(REQ_MEASURE, 32'sd7, 1'b0);
    add_item(REQ_CONVERT, 32'sd8, 1'b0);
    wait_idle();

    // Directed: byte mode ignores tracked bounds but still tracks them
    write_byte_mode(MODE_BYTE);
    add_item(REQ_CONVERT, 32'sd0, 1'b0);
    add_item(REQ_CONVERT, 32'sd255, 1'b0);
    add_item(REQ_CONVERT, 32'sd128, 1'b0);
    add_item(REQ_CONVERT, -32'sd1, 1'b0);
    add_item(REQ_CONVERT, 32'sd256, 1'b0);
    add_item(REQ_MEASURE, 32'sd1000, 1'b1);
    add_item(REQ_CONVERT, 32'sd100, 1'b0);
    wait_idle();
    write_byte_mode(MODE_RANGE);
    add_item(REQ_CONVERT, 32'sd1000, 1'b0);
    wait_idle();

    // Random phases with varying sender gaps and register setting
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_byte_mode(mode_tab[p]);
      idle_pct = idle_tab[p];
      budget = PHASE_ITEMS;
      while (budget > 0) queue_frame(budget);
      wait_idle();
    end

    if (level_q.size() != 0) begin
      $error("%0d expected results never arrived", level_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #4ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
